// ----- src/gbr_pkg.sv -----
// shared types and constants for the grid maze reachability block
`timescale 1ns / 1ps

package gbr_pkg;

  localparam int IdxW      = 9;
  localparam int CfgIndexW = 8;
  localparam int CfgDataW  = 7;

  localparam logic [CfgIndexW-1:0] REG_GRID_ROWS = 8'd0;
  localparam logic [CfgIndexW-1:0] REG_GRID_COLS = 8'd1;
  localparam logic [CfgIndexW-1:0] REG_EXIT_ROW  = 8'd2;
  localparam logic [CfgIndexW-1:0] REG_EXIT_COL  = 8'd3;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  typedef struct packed {
    logic       load;
    logic       start;
    logic       start_ok;
    logic       step;
    logic       wall;
    logic [5:0] row;
    logic [5:0] col;
    logic [5:0] exit_row;
    logic [5:0] exit_col;
  } cell_ctrl_t;

endpackage

// ----- src/gbr_if.sv -----
// handshake interfaces for the item, result and configuration channels
`timescale 1ns / 1ps

interface gbr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [5:0] cell_row;
  logic [5:0] cell_col;
  logic       is_wall;

  modport source (output valid, mode, cell_row, cell_col, is_wall, input ready);
  modport sink (input valid, mode, cell_row, cell_col, is_wall, output ready);
endinterface

interface gbr_out_if;
  logic valid;
  logic ready;
  logic exit_found;

  modport source (output valid, exit_found, input ready);
  modport sink (input valid, exit_found, output ready);
endinterface

interface gbr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gbr_pkg::CfgIndexW-1:0]  index;
  logic [gbr_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/gbr_cell.sv -----
// one grid row: wall bits, visited bits and the flood step toward its neighbors
`timescale 1ns / 1ps

module gbr_cell #(
  parameter int Idx  = 0,
  parameter int Cols = 64
) (
  input  logic                clk_i,
  input  gbr_pkg::cell_ctrl_t ctrl_i,
  input  logic                row_en_i,
  input  logic [Cols-1:0]     col_en_i,
  input  logic [Cols-1:0]     up_vis_i,
  input  logic [Cols-1:0]     dn_vis_i,
  output logic [Cols-1:0]     vis_o,
  output logic                changed_o,
  output logic                hit_o
);

  logic [Cols-1:0] wall_q, wall_d;
  logic [Cols-1:0] vis_q, vis_d;
  logic [Cols-1:0] grow;
  logic [Cols-1:0] col_oh;
  logic [Cols-1:0] exit_oh;
  logic            row_sel;
  logic            exit_sel;

  assign row_sel  = ({3'b000, ctrl_i.row} == gbr_pkg::IdxW'(Idx));
  assign exit_sel = ({3'b000, ctrl_i.exit_row} == gbr_pkg::IdxW'(Idx));

  always_comb begin
    for (int c = 0; c < Cols; c++) begin
      col_oh[c]  = ({3'b000, ctrl_i.col} == gbr_pkg::IdxW'(c));
      exit_oh[c] = ({3'b000, ctrl_i.exit_col} == gbr_pkg::IdxW'(c));
      wall_d[c]  = (ctrl_i.load && row_sel && col_oh[c]) ? ctrl_i.wall : wall_q[c];
    end
  end

  assign grow = (vis_q << 1) | (vis_q >> 1) | up_vis_i | dn_vis_i;

  always_comb begin
    vis_d = vis_q;
    if (ctrl_i.start) begin
      vis_d = (row_sel && ctrl_i.start_ok) ? col_oh : '0;
    end else if (ctrl_i.step) begin
      vis_d = vis_q | (grow & ~wall_q & col_en_i & {Cols{row_en_i}});
    end
  end

  always_ff @(posedge clk_i) begin
    wall_q <= wall_d;
    vis_q  <= vis_d;
  end

  assign vis_o     = vis_q;
  assign changed_o = ctrl_i.step && (vis_d != vis_q);
  assign hit_o     = exit_sel && (|(vis_q & exit_oh));

endmodule

// ----- src/grid_maze_bfs_reachability_core.sv -----
// Grid maze reachability: a load transaction writes one wall bit.
// A run transaction floods the visited set from the start cell through a column of
// row cells, one neighbor step per cycle, until the exit is reached or the set stops
// growing; the number of steps is at most the longest open path in cells, bounded by
// grid_rows * grid_cols. New transactions are taken while a result waits; a second run
// finishes only once the earlier result has been taken.
`timescale 1ns / 1ps

module grid_maze_bfs_reachability_core #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gbr_in_if.sink    in_i,
  gbr_out_if.source out_o,
  gbr_cfg_if.sink   cfg_i
);

  logic [6:0] grid_rows_q, grid_cols_q;
  logic [5:0] exit_row_q, exit_col_q;

  logic [gbr_pkg::IdxW-1:0] rows_eff, cols_eff;
  logic [MAX_ROWS-1:0]      row_en;
  logic [MAX_COLS-1:0]      col_en;

  gbr_pkg::state_e    state_q, state_d;
  gbr_pkg::cell_ctrl_t ctrl;

  logic in_acc, run_acc, load_acc, start_ok, finish, done, can_finish;
  logic same_q, same_d;
  logic out_valid_q, out_valid_d, exit_found_q, exit_found_d;
  logic hit_any, changed_any;

  logic [MAX_COLS-1:0] vis [MAX_ROWS];
  logic [MAX_ROWS-1:0] hit_vec, chg_vec;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= 7'd64;
      grid_cols_q <= 7'd64;
      exit_row_q  <= 6'd0;
      exit_col_q  <= 6'd0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        gbr_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_i.data[6:0];
        gbr_pkg::REG_GRID_COLS: grid_cols_q <= cfg_i.data[6:0];
        gbr_pkg::REG_EXIT_ROW:  exit_row_q  <= cfg_i.data[5:0];
        gbr_pkg::REG_EXIT_COL:  exit_col_q  <= cfg_i.data[5:0];
        default: ;
      endcase
    end
  end

  // clamped grid size and in-grid masks
  always_comb begin
    if (grid_rows_q == 7'd0) begin
      rows_eff = gbr_pkg::IdxW'(1);
    end else if ({2'b00, grid_rows_q} > gbr_pkg::IdxW'(MAX_ROWS)) begin
      rows_eff = gbr_pkg::IdxW'(MAX_ROWS);
    end else begin
      rows_eff = {2'b00, grid_rows_q};
    end
    if (grid_cols_q == 7'd0) begin
      cols_eff = gbr_pkg::IdxW'(1);
    end else if ({2'b00, grid_cols_q} > gbr_pkg::IdxW'(MAX_COLS)) begin
      cols_eff = gbr_pkg::IdxW'(MAX_COLS);
    end else begin
      cols_eff = {2'b00, grid_cols_q};
    end
    for (int r = 0; r < MAX_ROWS; r++) row_en[r] = (gbr_pkg::IdxW'(r) < rows_eff);
    for (int c = 0; c < MAX_COLS; c++) col_en[c] = (gbr_pkg::IdxW'(c) < cols_eff);
  end

  assign in_acc   = in_i.valid && in_i.ready;
  assign run_acc  = in_acc && (in_i.mode == gbr_pkg::MODE_RUN);
  assign load_acc = in_acc && (in_i.mode == gbr_pkg::MODE_LOAD);
  assign start_ok = ({3'b000, in_i.cell_row} < rows_eff) && ({3'b000, in_i.cell_col} < cols_eff);

  assign hit_any     = |hit_vec;
  assign changed_any = |chg_vec;
  assign done        = hit_any || !changed_any;
  assign can_finish  = !out_valid_q || out_o.ready;
  assign finish      = (state_q == gbr_pkg::ST_SEARCH) && done && can_finish;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gbr_pkg::ST_IDLE:   if (run_acc) state_d = gbr_pkg::ST_SEARCH;
      gbr_pkg::ST_SEARCH: if (done && can_finish) state_d = gbr_pkg::ST_IDLE;
      default:            state_d = gbr_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_i.ready    = (state_q == gbr_pkg::ST_IDLE);
    ctrl.load     = load_acc;
    ctrl.start    = run_acc;
    ctrl.start_ok = start_ok;
    ctrl.step     = (state_q == gbr_pkg::ST_SEARCH);
    ctrl.wall     = in_i.is_wall;
    ctrl.row      = in_i.cell_row;
    ctrl.col      = in_i.cell_col;
    ctrl.exit_row = exit_row_q;
    ctrl.exit_col = exit_col_q;
  end

  // result register
  always_comb begin
    same_d       = same_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    exit_found_d = exit_found_q;
    if (run_acc) same_d = (in_i.cell_row == exit_row_q) && (in_i.cell_col == exit_col_q);
    if (finish) begin
      out_valid_d  = 1'b1;
      exit_found_d = hit_any && !same_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    same_q       <= same_d;
    exit_found_q <= exit_found_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.exit_found = exit_found_q;

  // row cells
  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
    logic [MAX_COLS-1:0] up_vis, dn_vis;
    if (r == 0) begin : g_top
      assign up_vis = '0;
    end else begin : g_up
      assign up_vis = vis[r-1];
    end
    if (r == MAX_ROWS - 1) begin : g_bot
      assign dn_vis = '0;
    end else begin : g_dn
      assign dn_vis = vis[r+1];
    end
    gbr_cell #(
      .Idx  (r),
      .Cols (MAX_COLS)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .row_en_i  (row_en[r]),
      .col_en_i  (col_en),
      .up_vis_i  (up_vis),
      .dn_vis_i  (dn_vis),
      .vis_o     (vis[r]),
      .changed_o (chg_vec[r]),
      .hit_o     (hit_vec[r])
    );
  end

  // a new result only comes out of a search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == gbr_pkg::ST_SEARCH))
    else $error("result without search");

  // a settled search leaves or holds a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbr_pkg::ST_SEARCH) && !changed_any |=>
      (state_q == gbr_pkg::ST_IDLE) || out_valid_q)
    else $error("settled search did not finish");

endmodule

// ----- bench/grid_maze_bfs_reachability_core_test.sv -----
// testbench for the grid maze reachability core: random mazes checked against a search model
`timescale 1ns / 1ps

module grid_maze_bfs_reachability_core_test;

  localparam int Side = 64;
  localparam int Cells = Side * Side;

  typedef struct {
    logic       mode;
    logic [5:0] row;
    logic [5:0] col;
    logic       wall;
  } maze_item_t;

  typedef struct {
    logic [gbr_pkg::CfgIndexW-1:0] index;
    logic [gbr_pkg::CfgDataW-1:0]  data;
  } reg_write_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gbr_in_if  inb ();
  gbr_out_if outb ();
  gbr_cfg_if cfgb ();

  grid_maze_bfs_reachability_core uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (inb),
    .out_o (outb),
    .cfg_i (cfgb)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  maze_item_t pending_items[$];
  reg_write_t pending_writes[$];
  bit         expected_found[$];

  bit   wall_m[Cells];
  bit   seen_m[Cells];
  bit   loaded_m[Cells];
  int   frontier[Cells];
  int   m_rows = 64, m_cols = 64, m_exit_row = 0, m_exit_col = 0;
  int   errors = 0;
  int   cyc = 0;
  int   item_total = 0;
  bit   hold_go = 1'b0;
  bit   hold_on = 1'b0;

  function automatic int clamp_dim(int v);
    if (v < 1) return 1;
    if (v > Side) return Side;
    return v;
  endfunction

  function automatic bit exit_reachable(int sr, int sc);
    int rows, cols, head, tail, r, c, nr, nc, idx;
    rows = clamp_dim(m_rows);
    cols = clamp_dim(m_cols);
    foreach (seen_m[i]) seen_m[i] = 1'b0;
    if (sr >= rows || sc >= cols) return 1'b0;
    seen_m[sr * Side + sc] = 1'b1;
    frontier[0] = sr * Side + sc;
    head = 0;
    tail = 1;
    while (head < tail) begin
      r = frontier[head] / Side;
      c = frontier[head] % Side;
      head++;
      for (int d = 0; d < 4; d++) begin
        nr = r + (d == 0 ? -1 : d == 1 ? 1 : 0);
        nc = c + (d == 2 ? -1 : d == 3 ? 1 : 0);
        if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
        idx = nr * Side + nc;
        if (seen_m[idx] || wall_m[idx]) continue;
        if (nr == m_exit_row && nc == m_exit_col) return 1'b1;
        seen_m[idx] = 1'b1;
        frontier[tail] = idx;
        tail++;
      end
    end
    return 1'b0;
  endfunction

  // item driver, model updated at each accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    maze_item_t it;
    bit         found;
    if (!rst_ni) begin
      inb.valid <= 1'b0;
      inb.mode <= gbr_pkg::MODE_LOAD;
      inb.cell_row <= '0;
      inb.cell_col <= '0;
      inb.is_wall <= 1'b0;
    end else begin
      if (inb.valid && inb.ready) begin
        if (inb.mode == gbr_pkg::MODE_LOAD) begin
          wall_m[inb.cell_row * Side + inb.cell_col] = inb.is_wall;
        end else begin
          found = exit_reachable(int'(inb.cell_row), int'(inb.cell_col));
          expected_found = {expected_found, found};
        end
      end
      if (!inb.valid || inb.ready) begin
        if (pending_items.size() > 0 &&
            ((cyc >= 3000 && cyc < 6000) || $urandom_range(99) >= 23)) begin
          it = pending_items.pop_front();
          inb.valid <= 1'b1;
          inb.mode <= it.mode;
          inb.cell_row <= it.row;
          inb.cell_col <= it.col;
          inb.is_wall <= it.wall;
        end else begin
          inb.valid <= 1'b0;
        end
      end
    end
  end

  // register write driver
  always @(posedge clk_i or negedge rst_ni) begin
    reg_write_t w;
    if (!rst_ni) begin
      cfgb.valid <= 1'b0;
      cfgb.index <= '0;
      cfgb.data <= '0;
    end else begin
      if (cfgb.valid && cfgb.ready) begin
        case (cfgb.index)
          gbr_pkg::REG_GRID_ROWS: m_rows = int'(cfgb.data);
          gbr_pkg::REG_GRID_COLS: m_cols = int'(cfgb.data);
          gbr_pkg::REG_EXIT_ROW:  m_exit_row = int'(cfgb.data[5:0]);
          gbr_pkg::REG_EXIT_COL:  m_exit_col = int'(cfgb.data[5:0]);
          default: ;
        endcase
      end
      if (!cfgb.valid || cfgb.ready) begin
        if (pending_writes.size() > 0) begin
          w = pending_writes.pop_front();
          cfgb.valid <= 1'b1;
          cfgb.index <= w.index;
          cfgb.data <= w.data;
        end else begin
          cfgb.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    bit want;
    if (!rst_ni) begin
      outb.ready <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      if (outb.valid && outb.ready) begin
        if (expected_found.size() == 0) begin
          $display("%0t: unexpected result exit_found=%0b", $time, outb.exit_found);
          errors++;
        end else begin
          want = expected_found.pop_front();
          if (outb.exit_found !== want) begin
            $display("%0t: exit_found mismatch expected %0b actual %0b",
                     $time, want, outb.exit_found);
            errors++;
          end
        end
      end
      outb.ready <= !hold_on &&
                    ((cyc >= 3000 && cyc < 6000) || $urandom_range(99) >= 23);
    end
  end

  // long receiver hold so the block fills up and stalls its input
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (500) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  task automatic add_load(int r, int c, bit w);
    maze_item_t it;
    it.mode = gbr_pkg::MODE_LOAD;
    it.row = 6'(r);
    it.col = 6'(c);
    it.wall = w;
    loaded_m[r * Side + c] = 1'b1;
    pending_items = {pending_items, it};
    item_total++;
  endtask

  task automatic add_run(int r, int c);
    maze_item_t it;
    it.mode = gbr_pkg::MODE_RUN;
    it.row = 6'(r);
    it.col = 6'(c);
    it.wall = 1'($urandom_range(1));
    pending_items = {pending_items, it};
    item_total++;
  endtask

  task automatic wait_idle();
    wait (pending_items.size() == 0 && !inb.valid && expected_found.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_regs(int rows, int cols, int er, int ec);
    reg_write_t w;
    wait_idle();
    w.index = gbr_pkg::REG_GRID_ROWS; w.data = gbr_pkg::CfgDataW'(rows);
    pending_writes = {pending_writes, w};
    w.index = gbr_pkg::REG_GRID_COLS; w.data = gbr_pkg::CfgDataW'(cols);
    pending_writes = {pending_writes, w};
    w.index = gbr_pkg::REG_EXIT_ROW;  w.data = gbr_pkg::CfgDataW'(er);
    pending_writes = {pending_writes, w};
    w.index = gbr_pkg::REG_EXIT_COL;  w.data = gbr_pkg::CfgDataW'(ec);
    pending_writes = {pending_writes, w};
    if ($urandom_range(3) == 0) begin
      w.index = gbr_pkg::CfgIndexW'($urandom_range(255, 4));
      w.data = gbr_pkg::CfgDataW'($urandom);
      pending_writes = {pending_writes, w};
    end
    wait (pending_writes.size() == 0 && !cfgb.valid);
    repeat (2) @(posedge clk_i);
  endtask

  // every cell a search may read must hold a loaded wall bit
  task automatic fill_grid(int rows, int cols, int wall_pct);
    for (int r = 0; r < clamp_dim(rows); r++)
      for (int c = 0; c < clamp_dim(cols); c++)
        if (!loaded_m[r * Side + c]) add_load(r, c, $urandom_range(99) < wall_pct);
  endtask

  initial begin
    int rows, cols, er, ec, pct, phase_n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: corners of the full grid, start equal to exit, walls on start and exit
    set_regs(64, 64, 63, 63);
    add_load(0, 0, 1'b1);
    add_load(0, 1, 1'b0);
    add_load(1, 0, 1'b1);
    add_load(1, 1, 1'b0);
    add_load(0, 2, 1'b1);
    add_run(0, 0);
    add_load(62, 63, 1'b1);
    add_load(63, 62, 1'b0);
    add_load(62, 62, 1'b1);
    add_load(63, 61, 1'b1);
    add_load(63, 63, 1'b1);
    add_run(63, 63);
    add_run(63, 62);
    add_load(63, 63, 1'b0);
    add_run(63, 62);
    add_run(63, 63);
    add_load(0, 62, 1'b1);
    add_load(62, 0, 1'b1);
    set_regs(0, 127, 5, 5);
    add_run(0, 0);
    add_run(3, 0);
    add_run(0, 63);
    set_regs(127, 0, 63, 0);
    add_run(0, 0);
    add_run(63, 0);
    set_regs(2, 2, 1, 1);
    add_load(0, 1, 1'b1);
    add_load(1, 0, 1'b1);
    add_run(0, 0);
    add_load(1, 0, 1'b0);
    add_run(0, 0);

    phase_n = 0;
    while (item_total < 700) begin
      phase_n++;
      case ($urandom_range(19))
        0: begin rows = $urandom_range(1, 2); cols = $urandom_range(127, 64); end
        1: begin rows = $urandom_range(127, 65); cols = $urandom_range(1, 2); end
        2: begin rows = 0; cols = $urandom_range(0, 12); end
        3, 4: begin rows = $urandom_range(1, 16); cols = $urandom_range(1, 16); end
        default: begin rows = $urandom_range(1, 8); cols = $urandom_range(1, 8); end
      endcase
      er = $urandom_range(clamp_dim(rows) + ($urandom_range(4) == 0), 0);
      ec = $urandom_range(clamp_dim(cols) + ($urandom_range(4) == 0), 0);
      if (er > 63) er = 63;
      if (ec > 63) ec = 63;
      pct = $urandom_range(45, 10);
      set_regs(rows, cols, er, ec);
      fill_grid(rows, cols, pct);
      if (phase_n == 3) hold_go = 1'b1;
      for (int k = 0; k < 30; k++) begin
        if ($urandom_range(99) < 45) begin
          if ($urandom_range(9) == 0) add_run($urandom_range(63), $urandom_range(63));
          else add_run($urandom_range(clamp_dim(rows) - 1), $urandom_range(clamp_dim(cols) - 1));
        end else if ($urandom_range(9) == 0) begin
          add_load($urandom_range(63), $urandom_range(63), $urandom_range(1));
        end else begin
          add_load($urandom_range(clamp_dim(rows) - 1), $urandom_range(clamp_dim(cols) - 1),
                   $urandom_range(99) < pct);
        end
      end
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- grid_maze_bfs_reachability_core.f -----
src/gbr_pkg.sv
src/gbr_if.sv
src/gbr_cell.sv
src/grid_maze_bfs_reachability_core.sv
bench/grid_maze_bfs_reachability_core_test.sv
